// ===== hw/rtl/hrae_pkg.sv =====
// Shared types, constants and lookup functions for the hall rotor angle estimator.
`default_nettype none

package hrae_pkg;

    localparam int unsigned CODE_W    = 3;
    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned ELAPSED_W = 20;
    localparam int unsigned ANGLE_W   = 15;
    localparam int unsigned SECTOR_W  = 3;
    localparam int unsigned AVG_W     = 24;
    localparam int unsigned INV_W     = 16;

    // shared multiplier datapath
    localparam int unsigned REM_W  = 26;
    localparam int unsigned QUO_W  = 17;
    localparam int unsigned PROD_W = 43;
    localparam int unsigned SCL_W  = 47;
    localparam int unsigned MUL_W  = 27;
    localparam int unsigned MULP_W = 54;

    localparam int unsigned AVG_DIVISOR     = 150;
    localparam int unsigned US_PER_SEC      = 1000000;
    localparam int unsigned OFF_Q_BITS      = 12;

    // /150 as multiply by ceil(2^32/150), exact for dividends below 2^24
    localparam int unsigned AVG_RECIP_SHIFT = 32;
    localparam logic [MUL_W-1:0] AVG_RECIP =
        MUL_W'(((64'd1 << AVG_RECIP_SHIFT) + 64'(AVG_DIVISOR) - 64'd1) / 64'(AVG_DIVISOR));

    // /1e6 as >>6 then multiply by ceil(2^40/15625), exact for 26-bit dividends
    localparam int unsigned OFF_PRE_SHIFT   = 6;
    localparam int unsigned OFF_DIVISOR     = US_PER_SEC >> OFF_PRE_SHIFT;
    localparam int unsigned OFF_RECIP_SHIFT = 40;
    localparam logic [MUL_W-1:0] OFF_RECIP =
        MUL_W'(((64'd1 << OFF_RECIP_SHIFT) + 64'(OFF_DIVISOR) - 64'd1) / 64'(OFF_DIVISOR));

    localparam logic [ANGLE_W-1:0] SECTOR_SPAN = ANGLE_W'(3840);
    // offset clamps once the scaled product reaches (span + 1) * 1e6
    localparam logic [SCL_W-1:0]   CLAMP_LIMIT = SCL_W'(64'd3841000000);

    localparam logic [INV_W-1:0] INV_MAX = '1;

    localparam logic [CODE_W-1:0] CODE_S0 = 3'b100;
    localparam logic [CODE_W-1:0] CODE_S1 = 3'b110;
    localparam logic [CODE_W-1:0] CODE_S2 = 3'b010;
    localparam logic [CODE_W-1:0] CODE_S3 = 3'b011;
    localparam logic [CODE_W-1:0] CODE_S4 = 3'b001;
    localparam logic [CODE_W-1:0] CODE_S5 = 3'b101;

    typedef struct packed {
        logic                ok;
        logic [SECTOR_W-1:0] idx;
    } t_sector_info;

    function automatic t_sector_info code_to_sector(input logic [CODE_W-1:0] code);
        t_sector_info s;
        s.ok  = 1'b1;
        s.idx = '0;
        case (code)
            CODE_S0: s.idx = 3'd0;
            CODE_S1: s.idx = 3'd1;
            CODE_S2: s.idx = 3'd2;
            CODE_S3: s.idx = 3'd3;
            CODE_S4: s.idx = 3'd4;
            CODE_S5: s.idx = 3'd5;
            default: s.ok  = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [ANGLE_W-1:0] sector_base(input logic [SECTOR_W-1:0] idx);
        logic [ANGLE_W-1:0] b;
        case (idx)
            3'd0:    b = ANGLE_W'(0);
            3'd1:    b = SECTOR_SPAN;
            3'd2:    b = ANGLE_W'(7680);
            3'd3:    b = ANGLE_W'(11520);
            3'd4:    b = ANGLE_W'(15360);
            3'd5:    b = ANGLE_W'(19200);
            default: b = ANGLE_W'(0);
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hrae_if.sv =====
// Valid/ready channel interfaces for the hall sample input and the angle result.
`default_nettype none

interface hrae_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [hrae_pkg::CODE_W-1:0]          hall_code;
    logic signed [hrae_pkg::SPEED_W-1:0]  speed_sample;
    logic [hrae_pkg::ELAPSED_W-1:0]       elapsed_us;

    modport source (output valid, output hall_code, output speed_sample, output elapsed_us,
                    input ready);
    modport sink   (input valid, input hall_code, input speed_sample, input elapsed_us,
                    output ready);
endinterface

interface hrae_out_if;
    logic                                valid;
    logic                                ready;
    logic [hrae_pkg::ANGLE_W-1:0]        angle;
    logic                                code_valid;
    logic [hrae_pkg::SECTOR_W-1:0]       sector;
    logic signed [hrae_pkg::AVG_W-1:0]   average_speed;
    logic [hrae_pkg::INV_W-1:0]          invalid_total;

    modport source (output valid, output angle, output code_valid, output sector,
                    output average_speed, output invalid_total, input ready);
    modport sink   (input valid, input angle, input code_valid, input sector,
                    input average_speed, input invalid_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hall_rotor_angle_estimator.sv =====
// Hall rotor angle estimator: running speed average and in-sector angle interpolation.
// Sequence: a valid code steps through DIVA, UPD, MUL, SCALE, DIVB (skipped when the offset
//   clamps), BASE and FIN; an invalid code goes straight to FIN. FIN waits for a free output
//   register. One item at a time: ready only in idle. One shared 27x27 multiplier does both
//   reciprocal divisions and avg*elapsed.
// Synchronous active-low reset clears average, invalid count, held angle and sector.
`default_nettype none

module hall_rotor_angle_estimator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    hrae_in_if.sink     i_in,
    hrae_out_if.source  o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVA,   // (sample*256 - avg) / 150 by reciprocal
        ST_UPD,    // fold quotient into the average
        ST_MUL,    // avg * elapsed
        ST_SCALE,  // *15, clamp check, pre-shift by 64
        ST_DIVB,   // / 15625 by reciprocal
        ST_BASE,   // sector base + offset
        ST_FIN     // hand over to output register
    } t_state;

    t_state r_state;

    // held state
    logic signed [hrae_pkg::AVG_W-1:0]  r_avg;
    logic [hrae_pkg::INV_W-1:0]         r_inv;
    logic [hrae_pkg::ANGLE_W-1:0]       r_angle;
    logic [hrae_pkg::SECTOR_W-1:0]      r_sector;
    logic                               r_code_ok;

    // working registers
    logic [hrae_pkg::ELAPSED_W-1:0]     r_elapsed;
    logic [hrae_pkg::REM_W-1:0]         r_rem;
    logic [hrae_pkg::QUO_W-1:0]         r_quo;
    logic                               r_neg;
    logic [hrae_pkg::PROD_W-1:0]        r_prod;

    // output register
    logic                               r_ov;
    logic [hrae_pkg::ANGLE_W-1:0]       r_o_angle;
    logic                               r_o_code_ok;
    logic [hrae_pkg::SECTOR_W-1:0]      r_o_sector;
    logic signed [hrae_pkg::AVG_W-1:0]  r_o_avg;
    logic [hrae_pkg::INV_W-1:0]         r_o_inv;

    hrae_pkg::t_sector_info             w_sec;
    logic signed [hrae_pkg::AVG_W:0]    w_diff;
    logic [hrae_pkg::AVG_W:0]           w_mag;
    logic [hrae_pkg::MUL_W-1:0]         w_mul_a;
    logic [hrae_pkg::MUL_W-1:0]         w_mul_b;
    logic [hrae_pkg::MULP_W-1:0]        w_mul;
    logic signed [hrae_pkg::QUO_W:0]    w_q_s;
    logic signed [hrae_pkg::AVG_W:0]    w_avg_sum;
    logic [hrae_pkg::SCL_W-1:0]         w_prod15;
    logic [hrae_pkg::AVG_W-2:0]         w_avg_pos;
    logic                               w_in_beat;
    logic                               w_out_free;

    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_out_free = !r_ov || o_out.ready;

    assign w_sec  = hrae_pkg::code_to_sector(i_in.hall_code);

    // sample*256 - avg; magnitude fits 24 bits, sign kept for the quotient
    assign w_diff = $signed({i_in.speed_sample[hrae_pkg::SPEED_W-1], i_in.speed_sample, 8'b0})
                  - $signed({r_avg[hrae_pkg::AVG_W-1], r_avg});
    assign w_mag  = w_diff[hrae_pkg::AVG_W] ? (hrae_pkg::AVG_W + 1)'(-w_diff)
                                            : (hrae_pkg::AVG_W + 1)'(w_diff);

    // shared multiplier, operands picked by the sequencer
    always_comb begin
        case (r_state)
            ST_MUL: begin
                w_mul_a = hrae_pkg::MUL_W'(w_avg_pos);
                w_mul_b = hrae_pkg::MUL_W'(r_elapsed);
            end
            ST_DIVB: begin
                w_mul_a = hrae_pkg::MUL_W'(r_rem);
                w_mul_b = hrae_pkg::OFF_RECIP;
            end
            default: begin
                w_mul_a = hrae_pkg::MUL_W'(r_rem);
                w_mul_b = hrae_pkg::AVG_RECIP;
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    // quotient truncates toward zero: apply sign to the magnitude quotient
    assign w_q_s     = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_avg_sum = $signed({r_avg[hrae_pkg::AVG_W-1], r_avg})
                     + (hrae_pkg::AVG_W + 1)'(w_q_s);

    // non-positive average gives zero offset after the clamp
    assign w_avg_pos = r_avg[hrae_pkg::AVG_W-1] ? '0 : r_avg[hrae_pkg::AVG_W-2:0];

    // x15 as x16 - x1
    assign w_prod15 = {r_prod, 4'b0} - {4'b0, r_prod};

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.angle         = r_o_angle;
    assign o_out.code_valid    = r_o_code_ok;
    assign o_out.sector        = r_o_sector;
    assign o_out.average_speed = r_o_avg;
    assign o_out.invalid_total = r_o_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_avg     <= '0;
            r_inv     <= '0;
            r_angle   <= '0;
            r_sector  <= '0;
            r_code_ok <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            // ST_FIN reloads the output register itself
            if (r_ov && o_out.ready && r_state != ST_FIN) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_beat) begin
                        r_code_ok <= w_sec.ok;
                        r_elapsed <= i_in.elapsed_us;
                        if (w_sec.ok) begin
                            r_sector <= w_sec.idx;
                            r_neg    <= w_diff[hrae_pkg::AVG_W];
                            r_rem    <= hrae_pkg::REM_W'(w_mag[hrae_pkg::AVG_W-1:0]);
                            r_state  <= ST_DIVA;
                        end else begin
                            if (r_inv != hrae_pkg::INV_MAX) begin
                                r_inv <= r_inv + 1'b1;
                            end
                            r_state <= ST_FIN;
                        end
                    end
                end

                ST_DIVA: begin
                    r_quo   <= w_mul[hrae_pkg::AVG_RECIP_SHIFT +: hrae_pkg::QUO_W];
                    r_state <= ST_UPD;
                end

                ST_UPD: begin
                    r_avg   <= w_avg_sum[hrae_pkg::AVG_W-1:0];
                    r_state <= ST_MUL;
                end

                ST_MUL: begin
                    r_prod  <= w_mul[hrae_pkg::PROD_W-1:0];
                    r_state <= ST_SCALE;
                end

                ST_SCALE: begin
                    if (w_prod15 >= hrae_pkg::CLAMP_LIMIT) begin
                        r_quo   <= hrae_pkg::QUO_W'(hrae_pkg::SECTOR_SPAN);
                        r_state <= ST_BASE;
                    end else begin
                        // below the clamp the product fits 32 bits
                        r_rem   <= w_prod15[hrae_pkg::OFF_PRE_SHIFT +: hrae_pkg::REM_W];
                        r_state <= ST_DIVB;
                    end
                end

                ST_DIVB: begin
                    r_quo   <= hrae_pkg::QUO_W'(
                                   w_mul[hrae_pkg::OFF_RECIP_SHIFT +: hrae_pkg::OFF_Q_BITS]);
                    r_state <= ST_BASE;
                end

                ST_BASE: begin
                    r_angle <= hrae_pkg::sector_base(r_sector)
                             + hrae_pkg::ANGLE_W'(r_quo[hrae_pkg::OFF_Q_BITS-1:0]);
                    r_state <= ST_FIN;
                end

                ST_FIN: begin
                    if (w_out_free) begin
                        r_ov        <= 1'b1;
                        r_o_angle   <= r_angle;
                        r_o_code_ok <= r_code_ok;
                        r_o_sector  <= r_sector;
                        r_o_avg     <= r_avg;
                        r_o_inv     <= r_inv;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
